// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising edge outside reset.
`define MSDP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition is followed by a consequence in the next cycle.
`define MSDP_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/msdp_pkg.sv =====
// ----------------------------------------------------------------------------
// Drum positioner package
// Widths, codes, the half-step coil table and the controller interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package msdp_pkg;

  localparam int CELLS_DEF  = 8;
  localparam int HOME_DEF   = 9;

  localparam int MAXC_W     = 5;
  localparam int SPP_W      = 11;
  localparam int OWED_W     = 16;
  localparam int WORD_W     = 64;
  localparam int MODE_W     = 2;
  localparam int CELL_W     = 3;
  localparam int MASK_W     = 6;
  localparam int ACTION_W   = 2;
  localparam int PHASE_W    = 3;
  localparam int POS_W      = 3;
  localparam int COIL_W     = 4;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 11;

  localparam logic [MAXC_W-1:0] MAXC_RESET = 5'd4;
  localparam logic [SPP_W-1:0]  SPP_RESET  = 11'd512;

  localparam logic [CFG_INDEX_W-1:0] CFG_MAXC = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPP  = 1'b1;

  localparam logic [MODE_W-1:0] MODE_TICK = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SET  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HOME = 2'd2;

  localparam logic [ACTION_W-1:0] ACT_NONE  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_FRAME = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CUT   = 2'd2;

  typedef struct packed {
    logic capture;
    logic aim;
    logic side;
    logic home;
    logic walk_step;
    logic finish;
    logic res_tick;
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              cell_ok;
    logic              busy;
    logic              walk_last;
  } status_t;

  function automatic logic [COIL_W-1:0] coil_code(input logic [PHASE_W-1:0] phase);
    logic [COIL_W-1:0] code;
    unique case (phase)
      3'd0: code = 4'h8;
      3'd1: code = 4'hC;
      3'd2: code = 4'h4;
      3'd3: code = 4'h6;
      3'd4: code = 4'h2;
      3'd5: code = 4'h3;
      3'd6: code = 4'h1;
      3'd7: code = 4'h9;
      default: code = 4'h0;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/msdp_ctrl.sv =====
// ----------------------------------------------------------------------------
// Drum positioner controller
// Sequences one word at a time through decode, aim, home, drum walk and
// result hand-off, and owns both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module msdp_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire logic             out_stall,
  input  wire msdp_pkg::status_t status,
  output msdp_pkg::cmd_t        cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_AIM_L  = 3'd2;
  localparam logic [2:0] S_AIM_R  = 3'd3;
  localparam logic [2:0] S_HOME   = 3'd4;
  localparam logic [2:0] S_WALK   = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       res_tick;
  logic       res_tick_next;

  always_comb begin
    cmd           = '0;
    state_next    = state;
    res_tick_next = res_tick;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        res_tick_next = 1'b0;
        priority if (status.mode == msdp_pkg::MODE_SET && status.cell_ok) begin
          state_next = S_AIM_L;
        end else if (status.mode == msdp_pkg::MODE_HOME) begin
          state_next = S_HOME;
        end else if (status.mode == msdp_pkg::MODE_TICK && status.busy) begin
          res_tick_next = 1'b1;
          state_next    = S_WALK;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_AIM_L: begin
        cmd.aim    = 1'b1;
        cmd.side   = 1'b0;
        state_next = S_AIM_R;
      end
      S_AIM_R: begin
        cmd.aim    = 1'b1;
        cmd.side   = 1'b1;
        state_next = S_FINISH;
      end
      S_HOME: begin
        cmd.home   = 1'b1;
        state_next = S_FINISH;
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (status.walk_last) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid || !out_stall) begin
          cmd.finish   = 1'b1;
          cmd.res_tick = res_tick;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_tick  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      res_tick <= res_tick_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign in_stall = (state != S_IDLE);

  `MSDP_ASSERT_NEXT(a_accept_decodes, in_valid && !in_stall, state == S_DECODE, "accepted word did not reach decode")
  `MSDP_ASSERT(a_out_from_finish, $rose(out_valid) |-> $past(cmd.finish), "result shown without a finish")

endmodule

`default_nettype wire

// ===== rtl/msdp_datapath.sv =====
// ----------------------------------------------------------------------------
// Drum positioner datapath
// Holds the configuration, per-drum phase, position and owed half-steps, and
// the result register. Aim and walk update one drum per cycle, home every drum.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module msdp_datapath #(
  parameter int CELLS          = msdp_pkg::CELLS_DEF,
  parameter int HOME_POSITIONS = msdp_pkg::HOME_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire msdp_pkg::cmd_t                      cmd,
  output msdp_pkg::status_t                        status,
  input  wire logic [msdp_pkg::MODE_W-1:0]         mode,
  input  wire logic [msdp_pkg::CELL_W-1:0]         cell_req,
  input  wire logic [msdp_pkg::MASK_W-1:0]         mask,
  input  wire logic                                cfg_we,
  input  wire logic [msdp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [msdp_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic [msdp_pkg::WORD_W-1:0]              coil_word,
  output logic [msdp_pkg::ACTION_W-1:0]            action,
  output logic                                     ready_res
);

  localparam int DRUMS  = 2 * CELLS;
  localparam int DRUM_W = (DRUMS > 1) ? $clog2(DRUMS) : 1;
  localparam int HOME_W = $clog2(HOME_POSITIONS + 1);
  localparam int MAG_W  = msdp_pkg::SPP_W + HOME_W + 1;
  localparam int OW     = msdp_pkg::OWED_W;

  logic [msdp_pkg::MAXC_W-1:0]  max_conc;
  logic [msdp_pkg::SPP_W-1:0]   spp;
  logic [msdp_pkg::MODE_W-1:0]  mode_q;
  logic [msdp_pkg::CELL_W-1:0]  cell_q;
  logic [msdp_pkg::MASK_W-1:0]  mask_q;

  logic [msdp_pkg::PHASE_W-1:0] phase [DRUMS];
  logic [msdp_pkg::POS_W-1:0]   shown [DRUMS];
  logic signed [OW-1:0]         owed  [DRUMS];
  logic                         busy;
  logic [DRUM_W-1:0]            walk_idx;
  logic [msdp_pkg::MAXC_W-1:0]  stepped;
  logic                         owing;

  logic [DRUM_W-1:0]            sel;
  logic [msdp_pkg::POS_W-1:0]   want;
  logic signed [4:0]            delta_raw;
  logic signed [4:0]            delta;
  logic signed [16:0]           delta_x;
  logic signed [16:0]           spp_x;
  logic signed [16:0]           prod;
  logic signed [17:0]           sum;
  logic signed [OW-1:0]         aim_owed;
  logic signed [OW-1:0]         cur;
  logic [MAG_W-1:0]             home_mag;
  logic signed [OW-1:0]         home_back;
  logic                         can_step;
  logic                         busy_after;
  logic                         tick_cut;
  logic [msdp_pkg::WORD_W-1:0]  frame;

  assign sel  = cmd.aim ? DRUM_W'({cell_q, cmd.side}) : walk_idx;
  assign want = cmd.side ? mask_q[5:3] : mask_q[2:0];
  assign cur  = owed[sel];

  always_comb begin
    delta_raw = $signed({2'b00, want}) - $signed({2'b00, shown[sel]});
    if (delta_raw > 5'sd4) begin
      delta = delta_raw - 5'sd8;
    end else if (delta_raw < -5'sd4) begin
      delta = delta_raw + 5'sd8;
    end else begin
      delta = delta_raw;
    end
    delta_x = 17'(delta);
    spp_x   = $signed({6'b000000, spp});
    prod    = delta_x * spp_x;
    sum     = 18'(cur) + 18'(prod);
    if (sum > 18'sd32767) begin
      aim_owed = 16'sh7FFF;
    end else if (sum < -18'sd32768) begin
      aim_owed = 16'sh8000;
    end else begin
      aim_owed = sum[OW-1:0];
    end
  end

  always_comb begin
    home_mag = MAG_W'(spp) * MAG_W'(HOME_POSITIONS);
    if (home_mag > MAG_W'(32768)) begin
      home_back = 16'sh8000;
    end else begin
      home_back = OW'(MAG_W'(0) - home_mag);
    end
  end

  assign can_step   = (stepped < max_conc);
  assign tick_cut   = cmd.res_tick && (stepped == '0) && !owing;
  assign busy_after = tick_cut ? 1'b0 : busy;

  always_comb begin
    frame = '0;
    for (int d = 0; d < DRUMS; d++) begin
      frame[msdp_pkg::COIL_W*d +: msdp_pkg::COIL_W] = msdp_pkg::coil_code(phase[d]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_conc <= msdp_pkg::MAXC_RESET;
      spp      <= msdp_pkg::SPP_RESET;
      busy     <= 1'b0;
      walk_idx <= '0;
      stepped  <= '0;
      owing    <= 1'b0;
      for (int d = 0; d < DRUMS; d++) begin
        phase[d] <= '0;
        shown[d] <= '0;
        owed[d]  <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          msdp_pkg::CFG_MAXC: max_conc <= cfg_data[msdp_pkg::MAXC_W-1:0];
          msdp_pkg::CFG_SPP:  spp      <= cfg_data[msdp_pkg::SPP_W-1:0];
          default: ;
        endcase
      end
      if (cmd.capture) begin
        walk_idx <= '0;
        stepped  <= '0;
        owing    <= 1'b0;
      end
      if (cmd.aim) begin
        shown[sel] <= want;
        owed[sel]  <= aim_owed;
        busy       <= 1'b1;
      end
      if (cmd.home) begin
        for (int d = 0; d < DRUMS; d++) begin
          owed[d]  <= home_back;
          shown[d] <= '0;
        end
        busy <= 1'b1;
      end
      if (cmd.walk_step) begin
        walk_idx <= walk_idx + 1'b1;
        if (cur != '0) begin
          owing <= 1'b1;
          if (can_step) begin
            stepped <= stepped + 1'b1;
            if (!cur[OW-1]) begin
              phase[sel] <= phase[sel] + 1'b1;
              owed[sel]  <= cur - 16'sd1;
            end else begin
              phase[sel] <= phase[sel] - 1'b1;
              owed[sel]  <= cur + 16'sd1;
            end
          end
        end
      end
      if (cmd.finish) begin
        busy <= busy_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_q <= mode;
      cell_q <= cell_req;
      mask_q <= mask;
    end
    if (cmd.finish) begin
      ready_res <= !busy_after;
      if (cmd.res_tick && stepped != '0) begin
        coil_word <= frame;
        action    <= msdp_pkg::ACT_FRAME;
      end else if (tick_cut) begin
        coil_word <= '0;
        action    <= msdp_pkg::ACT_CUT;
      end else begin
        coil_word <= '0;
        action    <= msdp_pkg::ACT_NONE;
      end
    end
  end

  assign status.mode      = mode_q;
  assign status.cell_ok   = ({1'b0, cell_q} < 4'(CELLS));
  assign status.busy      = busy;
  assign status.walk_last = (walk_idx == DRUM_W'(DRUMS - 1));

  `MSDP_ASSERT_NEXT(a_step_limit, cmd.walk_step && stepped >= max_conc, stepped == $past(stepped), "drum stepped beyond the concurrency limit")
  `MSDP_ASSERT(a_idle_from_tick, $fell(busy) |-> $past(cmd.finish && cmd.res_tick), "busy cleared outside a finished tick")

endmodule

`default_nettype wire

// ===== rtl/multi_stepper_drum_positioner.sv =====
// ----------------------------------------------------------------------------
// Multi stepper drum positioner
// Two half-step stepper drums per cell: aiming, homing and coil sequencing.
// ----------------------------------------------------------------------------
// Input words carry mode, cell_req and mask on a valid/stall channel; every
// accepted word yields exactly one result word (coil_word, action, ready_res)
// on the output valid/stall channel. A set word for an existing cell aims its two
// drums, a home word makes every drum owe HOME_POSITIONS positions backwards, and a
// tick word steps up to the concurrency limit of owing drums and returns the coil
// frame if any drum stepped. Words are processed one at a time: decode, then left
// and right aim for a valid set word, home for a home word, or the walk over the
// drums at one drum per cycle for a tick that finds drums busy, then finish. A
// new word is accepted the cycle after a result is loaded into the output
// register, even while that result waits. Configuration is written through
// cfg_we, cfg_index and cfg_data and takes effect at once. Synchronous reset
// clears all phases, positions, owed steps and the busy flag and restores the
// register defaults. A stalled receiver holds the result steady and, once a
// further word is done, holds that word.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_stepper_drum_positioner #(
  parameter int CELLS          = msdp_pkg::CELLS_DEF,
  parameter int HOME_POSITIONS = msdp_pkg::HOME_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [msdp_pkg::MODE_W-1:0]      mode,
  input  wire logic [msdp_pkg::CELL_W-1:0]      cell_req,
  input  wire logic [msdp_pkg::MASK_W-1:0]      mask,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [msdp_pkg::WORD_W-1:0]           coil_word,
  output logic [msdp_pkg::ACTION_W-1:0]         action,
  output logic                                  ready_res,
  input  wire logic                             cfg_we,
  input  wire logic [msdp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [msdp_pkg::CFG_DATA_W-1:0]  cfg_data
);

  msdp_pkg::cmd_t    cmd;
  msdp_pkg::status_t status;

  msdp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  msdp_datapath #(
    .CELLS          (CELLS),
    .HOME_POSITIONS (HOME_POSITIONS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .mode      (mode),
    .cell_req  (cell_req),
    .mask      (mask),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coil_word (coil_word),
    .action    (action),
    .ready_res (ready_res)
  );

endmodule

`default_nettype wire

// ===== verif/multi_stepper_drum_positioner_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drum positioner testbench
// Drives set, home and tick words into the positioner and checks every
// result word against a cycle-free model of the drums. The model keeps its
// own phases, positions, owed half-steps and register copies. The run
// covers directed corner cases, randomized phases under several register
// settings, a long output hold-off and a final stretch without idling.
// ----------------------------------------------------------------------------

module multi_stepper_drum_positioner_tb;

  localparam int MODE_W      = msdp_pkg::MODE_W;
  localparam int CELL_W      = msdp_pkg::CELL_W;
  localparam int MASK_W      = msdp_pkg::MASK_W;
  localparam int WORD_W      = msdp_pkg::WORD_W;
  localparam int ACTION_W    = msdp_pkg::ACTION_W;
  localparam int COIL_W      = msdp_pkg::COIL_W;
  localparam int PHASE_W     = msdp_pkg::PHASE_W;
  localparam int POS_W       = msdp_pkg::POS_W;
  localparam int MAXC_W      = msdp_pkg::MAXC_W;
  localparam int SPP_W       = msdp_pkg::SPP_W;
  localparam int CFG_INDEX_W = msdp_pkg::CFG_INDEX_W;
  localparam int CFG_DATA_W  = msdp_pkg::CFG_DATA_W;

  localparam int DRUMS = 2 * msdp_pkg::CELLS_DEF;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam logic [COIL_W-1:0] COIL_SEQ [8] = '{4'h8, 4'hC, 4'h4, 4'h6,
                                                4'h2, 4'h3, 4'h1, 4'h9};

  typedef struct {
    logic [WORD_W-1:0]   coil_word;
    logic [ACTION_W-1:0] action;
    logic                ready_res;
  } drum_result_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [MODE_W-1:0] word_mode;
  logic [CELL_W-1:0] word_cell;
  logic [MASK_W-1:0] word_mask;
  logic out_valid;
  logic out_stall;
  logic [WORD_W-1:0] coil_word;
  logic [ACTION_W-1:0] action;
  logic ready_res;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  logic [PHASE_W-1:0] phase_q [DRUMS];
  logic [POS_W-1:0]   pos_q [DRUMS];
  int                 owed_q [DRUMS];
  bit                 busy_q;
  logic [MAXC_W-1:0]  maxc_q;
  logic [SPP_W-1:0]   spp_q;

  drum_result_t coil_results_q [$];
  int mismatches;
  int quiet_cycles;
  int stall_left;
  bit tx_idle_en;
  bit rx_idle_en;
  bit hold_req;

  multi_stepper_drum_positioner uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (word_mode),
    .cell_req  (word_cell),
    .mask      (word_mask),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .coil_word (coil_word),
    .action    (action),
    .ready_res (ready_res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int clamp_owed(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic void aim_drum(input int d, input logic [POS_W-1:0] want);
    int delta;
    delta = int'(want) - int'(pos_q[d]);
    if (delta > 4) delta -= 8;
    if (delta < -4) delta += 8;
    owed_q[d] = clamp_owed(owed_q[d] + delta * int'(spp_q));
    pos_q[d] = want;
  endfunction

  function automatic drum_result_t advance_drums(input logic [MODE_W-1:0] m,
                                                 input logic [CELL_W-1:0] c,
                                                 input logic [MASK_W-1:0] msk);
    drum_result_t r;
    int stepped;
    bit owing;
    int back;
    r.coil_word = '0;
    r.action = msdp_pkg::ACT_NONE;
    stepped = 0;
    owing = 1'b0;
    if (m == msdp_pkg::MODE_SET && int'(c) < msdp_pkg::CELLS_DEF) begin
      aim_drum(2 * int'(c), msk[2:0]);
      aim_drum(2 * int'(c) + 1, msk[5:3]);
      busy_q = 1'b1;
    end else if (m == msdp_pkg::MODE_HOME) begin
      back = clamp_owed(-(int'(spp_q) * msdp_pkg::HOME_DEF));
      for (int d = 0; d < DRUMS; d++) begin
        owed_q[d] = back;
        pos_q[d] = '0;
      end
      busy_q = 1'b1;
    end else if (m == msdp_pkg::MODE_TICK && busy_q) begin
      for (int d = 0; d < DRUMS; d++) begin
        if (owed_q[d] != 0) begin
          owing = 1'b1;
          if (stepped < int'(maxc_q)) begin
            if (owed_q[d] > 0) begin
              phase_q[d] = phase_q[d] + 3'd1;
              owed_q[d]--;
            end else begin
              phase_q[d] = phase_q[d] - 3'd1;
              owed_q[d]++;
            end
            stepped++;
          end
        end
      end
      if (stepped > 0) begin
        for (int d = 0; d < DRUMS; d++)
          r.coil_word |= WORD_W'(COIL_SEQ[phase_q[d]]) << (COIL_W * d);
        r.action = msdp_pkg::ACT_FRAME;
      end else if (!owing) begin
        busy_q = 1'b0;
        r.action = msdp_pkg::ACT_CUT;
      end
    end
    r.ready_res = !busy_q;
    return r;
  endfunction

  task automatic send_word(input logic [MODE_W-1:0] m, input logic [CELL_W-1:0] c,
                           input logic [MASK_W-1:0] msk);
    int gap;
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    word_mode <= m;
    word_cell <= c;
    word_mask <= msk;
    do @(posedge clk); while (in_stall);
    coil_results_q.push_back(advance_drums(m, c, msk));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (coil_results_q.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  task automatic write_regs(input int maxc, input int spp);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= msdp_pkg::CFG_MAXC;
    cfg_data <= CFG_DATA_W'(maxc);
    @(posedge clk);
    cfg_index <= msdp_pkg::CFG_SPP;
    cfg_data <= CFG_DATA_W'(spp);
    @(posedge clk);
    cfg_we <= 1'b0;
    maxc_q = MAXC_W'(maxc);
    spp_q = SPP_W'(spp);
  endtask

  task automatic run_phase(input int maxc, input int spp, input int count, input bit hold);
    int sent;
    int pick;
    write_regs(maxc, spp);
    if (hold) hold_req = 1'b1;
    send_word(msdp_pkg::MODE_HOME, CELL_W'($urandom), MASK_W'($urandom));
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_word(msdp_pkg::MODE_TICK, CELL_W'($urandom), MASK_W'($urandom));
      end else if (pick < 87) begin
        send_word(msdp_pkg::MODE_SET, CELL_W'($urandom), MASK_W'($urandom));
      end else if (pick < 92) begin
        send_word(msdp_pkg::MODE_HOME, CELL_W'($urandom), MASK_W'($urandom));
      end else begin
        send_word(MODE_UNUSED, CELL_W'($urandom), MASK_W'($urandom));
      end
      sent++;
    end
  endtask

  task automatic test_idle_and_unused();
    send_word(msdp_pkg::MODE_TICK, 3'd0, 6'd0);
    send_word(MODE_UNUSED, 3'd7, 6'd63);
  endtask

  task automatic test_aim_and_cut();
    write_regs(16, 1);
    send_word(msdp_pkg::MODE_SET, 3'd0, 6'd0);
    send_word(msdp_pkg::MODE_TICK, 3'd7, 6'd63);
    send_word(msdp_pkg::MODE_SET, 3'd7, 6'd63);
    send_word(msdp_pkg::MODE_SET, 3'd3, 6'b100_100);
    send_word(msdp_pkg::MODE_TICK, 3'd0, 6'd0);
  endtask

  task automatic test_owed_saturation();
    logic [POS_W-1:0] target;
    write_regs(1, 2047);
    target = 3'd0;
    repeat (6) begin
      target = target + 3'd3;
      send_word(msdp_pkg::MODE_SET, 3'd2, {3'd0, target});
    end
  endtask

  task automatic test_zero_concurrency();
    write_regs(0, 2047);
    send_word(msdp_pkg::MODE_TICK, 3'd0, 6'd0);
  endtask

  task automatic test_homing();
    write_regs(16, 1);
    send_word(msdp_pkg::MODE_HOME, 3'd0, 6'd0);
    repeat (10) send_word(msdp_pkg::MODE_TICK, 3'd0, 6'd0);
  endtask

  task automatic test_random_phases();
    int maxc_set [11] = '{4, 16, 1, 31, 8, 2, 0, 16, 5, 3, 12};
    int spp_set [11]  = '{1, 2, 1, 3, 1, 4, 1, 1, 1024, 2047, 1};
    int len_set [11]  = '{110, 110, 90, 90, 90, 70, 20, 70, 15, 12, 70};
    for (int k = 0; k < 11; k++) begin
      tx_idle_en = $urandom_range(0, 3) != 0;
      rx_idle_en = $urandom_range(0, 3) != 0;
      run_phase(maxc_set[k], spp_set[k], len_set[k], 1'b0);
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    run_phase($urandom_range(1, 16), $urandom_range(1, 6), 60, 1'b0);
  endtask

  task automatic test_output_backpressure();
    tx_idle_en = 1'b0;
    run_phase(16, 1, 40, 1'b1);
  endtask

  task automatic test_steady_stream();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    run_phase(7, 2, 60, 1'b0);
  endtask

  always @(posedge clk) begin
    drum_result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (coil_results_q.size() == 0) begin
        $error("unexpected result word: coil_word %h action %0d ready_res %0d",
               coil_word, action, ready_res);
        mismatches++;
      end else begin
        exp_r = coil_results_q.pop_front();
        if (coil_word !== exp_r.coil_word) begin
          $error("coil_word: expected %h actual %h", exp_r.coil_word, coil_word);
          mismatches++;
        end
        if (action !== exp_r.action) begin
          $error("action: expected %0d actual %0d", exp_r.action, action);
          mismatches++;
        end
        if (ready_res !== exp_r.ready_res) begin
          $error("ready_res: expected %0d actual %0d", exp_r.ready_res, ready_res);
          mismatches++;
        end
      end
    end
    if (hold_req) begin
      hold_req = 1'b0;
      stall_left = HOLD_CYCLES;
    end else if (stall_left > 0) begin
      stall_left--;
    end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 18);
    end
    out_stall <= (stall_left > 0);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    word_mode = msdp_pkg::MODE_TICK;
    word_cell = '0;
    word_mask = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = msdp_pkg::CFG_MAXC;
    cfg_data = '0;
    mismatches = 0;
    quiet_cycles = 0;
    stall_left = 0;
    hold_req = 1'b0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    for (int d = 0; d < DRUMS; d++) begin
      phase_q[d] = '0;
      pos_q[d] = '0;
      owed_q[d] = 0;
    end
    busy_q = 1'b0;
    maxc_q = msdp_pkg::MAXC_RESET;
    spp_q = msdp_pkg::SPP_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_idle_and_unused();
    test_aim_and_cut();
    test_owed_saturation();
    test_zero_concurrency();
    test_homing();
    test_random_phases();
    test_output_backpressure();
    test_steady_stream();

    settle();
    if (mismatches == 0 && coil_results_q.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
